### hw/rtl/mclfe_pkg.sv
// ----------------------------------------------------------------------------
// mclfe_pkg
// Shared constants and types of the linear fade engine.
// ----------------------------------------------------------------------------
package mclfe_pkg;
  localparam int MAX_JOBS   = 8;
  localparam int LEVEL_BITS = 16;
  localparam int STEP_BITS  = 15;
  localparam int CHAN_BITS  = 8;
  localparam int IDX_BITS   = $clog2(MAX_JOBS);
  localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
  localparam int JOB_BITS   = 2 * LEVEL_BITS + 2 * STEP_BITS + CHAN_BITS;
  localparam int PROD_BITS  = LEVEL_BITS + 1 + STEP_BITS + 1;
  localparam int NUM_BITS   = PROD_BITS + 1;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] start_lvl;
    logic signed [LEVEL_BITS-1:0] end_lvl;
    logic [STEP_BITS-1:0]         step;
    logic [STEP_BITS-1:0]         total;
    logic [CHAN_BITS-1:0]         chan;
  } job_t;
endpackage

### hw/rtl/mclfe_ram.sv
// ----------------------------------------------------------------------------
// mclfe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mclfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/multi_channel_linear_fade_engine_core.sv
// ----------------------------------------------------------------------------
// multi_channel_linear_fade_engine_core
// Fade job table in RAM; ticks walk jobs in order, compacting the table.
// Add: acknowledge strobe in the cycle right after the request is accepted.
// Tick: per job a read, a multiply-add, a bit-serial restoring division and
//   an emit.
// Busy throughout a tick; an add never raises busy; results cannot be stalled.
// Sync reset empties the table.
// ----------------------------------------------------------------------------
module multi_channel_linear_fade_engine_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  func,
  input  logic signed [mclfe_pkg::LEVEL_BITS-1:0] start_level,
  input  logic signed [mclfe_pkg::LEVEL_BITS-1:0] end_level,
  input  logic [mclfe_pkg::STEP_BITS-1:0]       step_total,
  input  logic [mclfe_pkg::CHAN_BITS-1:0]       channel,
  output logic                                  strobe,
  output logic [mclfe_pkg::CHAN_BITS-1:0]       out_channel,
  output logic signed [mclfe_pkg::LEVEL_BITS-1:0] level,
  output logic                                  finished,
  output logic                                  last,
  output logic                                  is_ack,
  output logic [mclfe_pkg::CNT_BITS-1:0]        job_count,
  output logic                                  add_error
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_EMIT} state_t;

  localparam int NB = mclfe_pkg::NUM_BITS;
  localparam int DB = mclfe_pkg::STEP_BITS;
  localparam int LB = mclfe_pkg::LEVEL_BITS;
  localparam int IB = mclfe_pkg::IDX_BITS;
  localparam int CB = mclfe_pkg::CNT_BITS;

  state_t                 state;
  logic [CB-1:0]          active;
  logic [CB-1:0]          rd;
  logic [CB-1:0]          wr;
  logic [CB-1:0]          n;
  logic                   we;
  logic [IB-1:0]          waddr;
  mclfe_pkg::job_t        wdata;
  mclfe_pkg::job_t        rdata;
  mclfe_pkg::job_t        job;
  logic [NB-1:0]          quo;
  logic [DB:0]            rem;
  logic                   neg;
  logic [$clog2(NB+1)-1:0] bitcnt;
  logic [DB+1:0]          trial;

  mclfe_ram #(.WIDTH(mclfe_pkg::JOB_BITS), .DEPTH(mclfe_pkg::MAX_JOBS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd[IB-1:0]),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    trial = {rem, quo[NB-1]} - {2'b00, job.total};
  end

  always_ff @(posedge clk) begin
    logic signed [NB-1:0] num;
    logic [CB-1:0] cnt;
    we     <= 1'b0;
    strobe <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (func == mclfe_pkg::FUNC_ADD) begin
              out_channel <= '0;
              level       <= '0;
              finished    <= 1'b0;
              last        <= 1'b1;
              is_ack      <= 1'b1;
              strobe      <= 1'b1;
              if (step_total == '0 || active >= CB'(mclfe_pkg::MAX_JOBS)) begin
                add_error <= 1'b1;
                job_count <= active;
              end else begin
                add_error   <= 1'b0;
                we          <= 1'b1;
                waddr       <= active[IB-1:0];
                wdata       <= '{start_level, end_level, DB'(1), step_total, channel};
                active      <= active + 1'b1;
                job_count   <= active + 1'b1;
              end
            end else if (active != '0) begin
              rd    <= '0;
              wr    <= '0;
              n     <= active;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_MUL;
        S_MUL: begin
          job <= rdata;
          num = NB'((rdata.end_lvl - rdata.start_lvl) * $signed({1'b0, rdata.step}))
              + NB'(rdata.start_lvl * $signed({1'b0, rdata.total}));
          neg    <= num[NB-1];
          quo    <= num[NB-1] ? NB'(-num) : num;
          rem    <= '0;
          bitcnt <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (trial[DB+1]) begin
            rem <= (DB+1)'({rem, quo[NB-1]});
            quo <= {quo[NB-2:0], 1'b0};
          end else begin
            rem <= trial[DB:0];
            quo <= {quo[NB-2:0], 1'b1};
          end
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == ($bits(bitcnt))'(NB - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          cnt = active;
          if (job.step >= job.total) begin
            cnt = active - 1'b1;
          end else begin
            we    <= 1'b1;
            waddr <= wr[IB-1:0];
            wdata <= '{job.start_lvl, job.end_lvl, job.step + 1'b1, job.total, job.chan};
            wr    <= wr + 1'b1;
          end
          active      <= cnt;
          strobe      <= 1'b1;
          out_channel <= job.chan;
          level       <= neg ? LB'(-quo) : LB'(quo);
          finished    <= (job.step >= job.total);
          last        <= (rd + 1'b1 == n);
          is_ack      <= 1'b0;
          add_error   <= 1'b0;
          job_count   <= cnt;
          rd          <= rd + 1'b1;
          state       <= (rd + 1'b1 == n) ? S_IDLE : S_READ;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/mclfe_checker.sv
// ----------------------------------------------------------------------------
// mclfe_checker
// Port-level checks of the fade engine core.
// ----------------------------------------------------------------------------
module mclfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          func,
  input logic                          strobe,
  input logic                          finished,
  input logic                          is_ack,
  input logic                          last,
  input logic                          add_error,
  input logic [mclfe_pkg::CNT_BITS-1:0] job_count
);
  a_add_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == mclfe_pkg::FUNC_ADD |=> strobe && is_ack && last)
    else $error("add without acknowledge");
  a_ack_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && is_ack |-> !finished)
    else $error("acknowledge marked finished");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> job_count <= mclfe_pkg::CNT_BITS'(mclfe_pkg::MAX_JOBS))
    else $error("job count out of range");
  a_err_ack: assert property (@(posedge clk) disable iff (rst)
    strobe && add_error |-> is_ack)
    else $error("error on level result");
endmodule

bind multi_channel_linear_fade_engine_core mclfe_checker u_mclfe_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .strobe(strobe),
  .finished(finished), .is_ack(is_ack), .last(last), .add_error(add_error),
  .job_count(job_count)
);

### dv/tb_multi_channel_linear_fade_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_linear_fade_engine_core
// Drives add and tick requests with random gaps into the fade engine.
// Predicts every acknowledge and level result and checks them in order.
// ----------------------------------------------------------------------------
module tb_multi_channel_linear_fade_engine_core;

  typedef struct {
    logic                             drain;
    logic                             fn;
    logic [mclfe_pkg::LEVEL_BITS-1:0] s_lvl;
    logic [mclfe_pkg::LEVEL_BITS-1:0] e_lvl;
    logic [mclfe_pkg::STEP_BITS-1:0]  steps;
    logic [mclfe_pkg::CHAN_BITS-1:0]  chan;
  } fade_req_t;

  typedef struct {
    logic [mclfe_pkg::CHAN_BITS-1:0]  chan;
    logic [mclfe_pkg::LEVEL_BITS-1:0] lvl;
    logic                             fin;
    logic                             lst;
    logic                             ack;
    logic [mclfe_pkg::CNT_BITS-1:0]   cnt;
    logic                             err;
  } fade_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = mclfe_pkg::FUNC_ADD;
  logic signed [mclfe_pkg::LEVEL_BITS-1:0] start_level = '0;
  logic signed [mclfe_pkg::LEVEL_BITS-1:0] end_level = '0;
  logic [mclfe_pkg::STEP_BITS-1:0] step_total = '0;
  logic [mclfe_pkg::CHAN_BITS-1:0] channel = '0;
  logic strobe;
  logic [mclfe_pkg::CHAN_BITS-1:0] out_channel;
  logic signed [mclfe_pkg::LEVEL_BITS-1:0] level;
  logic finished;
  logic last;
  logic is_ack;
  logic [mclfe_pkg::CNT_BITS-1:0] job_count;
  logic add_error;

  fade_req_t req_q[$];
  fade_res_t res_q[$];
  int errors = 0;
  int gap = 0;
  int hold = 0;
  logic draining = 1'b0;
  longint cycles = 0;

  longint tbl_start[mclfe_pkg::MAX_JOBS];
  longint tbl_end[mclfe_pkg::MAX_JOBS];
  longint tbl_step[mclfe_pkg::MAX_JOBS];
  longint tbl_total[mclfe_pkg::MAX_JOBS];
  logic [mclfe_pkg::CHAN_BITS-1:0] tbl_chan[mclfe_pkg::MAX_JOBS];
  int n_jobs = 0;

  multi_channel_linear_fade_engine_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .start_level(start_level), .end_level(end_level), .step_total(step_total),
    .channel(channel), .strobe(strobe), .out_channel(out_channel), .level(level),
    .finished(finished), .last(last), .is_ack(is_ack), .job_count(job_count),
    .add_error(add_error)
  );

  always #5 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_fade(input fade_req_t r);
    fade_res_t e;
    int wr;
    longint s, d, tot, st, lv;
    int first;
    e = '{chan: '0, lvl: '0, fin: 1'b0, lst: 1'b1, ack: 1'b1, cnt: '0, err: 1'b0};
    if (r.fn == mclfe_pkg::FUNC_ADD) begin
      if (r.steps == 0 || n_jobs >= mclfe_pkg::MAX_JOBS) begin
        e.err = 1'b1;
      end else begin
        tbl_start[n_jobs] = longint'($signed(r.s_lvl));
        tbl_end[n_jobs] = longint'($signed(r.e_lvl));
        tbl_step[n_jobs] = 1;
        tbl_total[n_jobs] = longint'(r.steps);
        tbl_chan[n_jobs] = r.chan;
        n_jobs++;
      end
      e.cnt = mclfe_pkg::CNT_BITS'(n_jobs);
      res_q.push_back(e);
    end else begin
      wr = 0;
      first = res_q.size();
      for (int rd = 0; rd < n_jobs; rd++) begin
        s = tbl_start[rd];
        d = tbl_end[rd] - s;
        tot = tbl_total[rd];
        st = tbl_step[rd];
        lv = (d * st + s * tot) / tot;
        e.chan = tbl_chan[rd];
        e.lvl = lv[mclfe_pkg::LEVEL_BITS-1:0];
        e.fin = (st >= tot);
        e.lst = 1'b0;
        e.ack = 1'b0;
        if (!e.fin) begin
          tbl_start[wr] = tbl_start[rd];
          tbl_end[wr] = tbl_end[rd];
          tbl_step[wr] = st + 1;
          tbl_total[wr] = tot;
          tbl_chan[wr] = tbl_chan[rd];
          wr++;
        end
        e.cnt = mclfe_pkg::CNT_BITS'(wr + (n_jobs - rd - 1));
        res_q.push_back(e);
      end
      if (res_q.size() > first) res_q[res_q.size()-1].lst = 1'b1;
      n_jobs = wr;
    end
  endtask

  function automatic fade_req_t add_req(input int s, input int e, input int n, input int c);
    fade_req_t r;
    r = '{drain: 1'b0, fn: mclfe_pkg::FUNC_ADD,
          s_lvl: mclfe_pkg::LEVEL_BITS'(s), e_lvl: mclfe_pkg::LEVEL_BITS'(e),
          steps: mclfe_pkg::STEP_BITS'(n), chan: mclfe_pkg::CHAN_BITS'(c)};
    return r;
  endfunction

  function automatic fade_req_t tick_req();
    fade_req_t r;
    r = '{drain: 1'b0, fn: mclfe_pkg::FUNC_TICK,
          s_lvl: mclfe_pkg::LEVEL_BITS'($urandom), e_lvl: mclfe_pkg::LEVEL_BITS'($urandom),
          steps: mclfe_pkg::STEP_BITS'($urandom), chan: mclfe_pkg::CHAN_BITS'($urandom)};
    return r;
  endfunction

  task automatic load(input fade_req_t r);
    func <= r.fn;
    start_level <= r.s_lvl;
    end_level <= r.e_lvl;
    step_total <= r.steps;
    channel <= r.chan;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_fade(req_q.pop_front());
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap == 0 && req_q.size() > 0 && !req_q[0].drain) begin
          load(req_q[0]);
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (draining) begin
          if (res_q.size() == 0 && !busy) begin
            if (hold > 0) hold--;
            else draining = 1'b0;
          end
        end else if (gap > 0) begin
          gap--;
        end else if (req_q.size() > 0) begin
          if (req_q[0].drain) begin
            void'(req_q.pop_front());
            draining = 1'b1;
            hold = 60;
          end else begin
            load(req_q[0]);
            start <= 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    fade_res_t e;
    if (!rst && strobe) begin
      if (res_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = res_q.pop_front();
        if (out_channel !== e.chan) report("out_channel", out_channel, e.chan);
        if (level !== e.lvl) report("level", level, $signed(e.lvl));
        if (finished !== e.fin) report("finished", finished, e.fin);
        if (last !== e.lst) report("last", last, e.lst);
        if (is_ack !== e.ack) report("is_ack", is_ack, e.ack);
        if (job_count !== e.cnt) report("job_count", job_count, e.cnt);
        if (add_error !== e.err) report("add_error", add_error, e.err);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    fade_req_t r;
    int steps;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    req_q.push_back(tick_req());
    req_q.push_back(add_req(100, 200, 0, 3));
    req_q.push_back(add_req(-32768, 32767, 1, 0));
    req_q.push_back(add_req(32767, -32768, 2, 255));
    req_q.push_back(add_req(-32768, 32767, 32767, 170));
    req_q.push_back(add_req(32767, -32768, 3, 85));
    req_q.push_back(add_req(-1, 1, 5, 1));
    req_q.push_back(add_req(0, -32768, 7, 2));
    req_q.push_back(add_req(32767, 32767, 4, 4));
    req_q.push_back(add_req(-5, 5, 6, 5));
    req_q.push_back(add_req(1, 2, 3, 6));
    req_q.push_back(tick_req());
    r = tick_req();
    r.drain = 1'b1;
    req_q.push_back(r);
    for (int i = 0; i < 8; i++) req_q.push_back(tick_req());
    for (int i = 0; i < 500; i++) begin
      if (i == 250) begin
        r = tick_req();
        r.drain = 1'b1;
        req_q.push_back(r);
      end
      if ($urandom_range(0, 1) == 0) begin
        req_q.push_back(tick_req());
      end else begin
        steps = $urandom_range(1, 12);
        if ($urandom_range(0, 19) == 0) steps = $urandom_range(0, 150);
        if ($urandom_range(0, 29) == 0) steps = 0;
        req_q.push_back(add_req($urandom, $urandom, steps, $urandom));
      end
    end
    wait (req_q.size() == 0 && !start && res_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && res_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
